/* rtl/spp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, codes and sizes for the subset pair finder.
// ----------------------------------------------------------------------------
package spp_pkg;

	localparam int MAX_SETS     = 256;
	localparam int MAX_VERTICES = 64;
	localparam int IDX_W        = $clog2(MAX_SETS);
	localparam int CNT_W        = $clog2(MAX_SETS + 1);
	localparam int MASK_W       = 64;
	localparam int OUT_IDX_W    = 8;

	localparam logic [MASK_W-1:0] VERTEX_MASK = (MAX_VERTICES >= MASK_W) ? {MASK_W{1'b1}} :
		((MASK_W'(1) << MAX_VERTICES) - MASK_W'(1));

	localparam logic [CNT_W-1:0] SET_LIMIT = CNT_W'(MAX_SETS);

	// function codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;

	// status codes
	localparam logic [2:0] STAT_PAIR    = 3'd0;
	localparam logic [2:0] STAT_DONE    = 3'd1;
	localparam logic [2:0] STAT_STORED  = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_CLEARED = 3'd4;

	typedef struct packed {
		logic [1:0]        func;
		logic [MASK_W-1:0] set_members;
	} spp_cmd_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [OUT_IDX_W-1:0] superset_index;
		logic [OUT_IDX_W-1:0] subset_index;
	} spp_result_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [MASK_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} spp_mem_req_t;

	// low bits of an index for the result word
	function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [CNT_W-1:0] idx);
		logic [CNT_W+OUT_IDX_W-1:0] wide;
		wide = {{OUT_IDX_W{1'b0}}, idx};
		return wide[OUT_IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/spp_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spp_store
// Set mask memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spp_store
	import spp_pkg::*;
(
	input  wire logic              clk,
	input  wire spp_mem_req_t      req,
	output logic [MASK_W-1:0]      rdata
);

	logic [MASK_W-1:0] mem [MAX_SETS];
	logic [MASK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/spp_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spp_seq
// Command sequencer: set count, scan cursors and the shared containment
// compare, one candidate subset per cycle while a superset is scanned.
// ----------------------------------------------------------------------------
module spp_seq
	import spp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire spp_cmd_t          cmd,
	output logic                   busy,
	output logic                   done,
	output spp_result_t            result,
	output spp_mem_req_t           mem_req,
	input  wire logic [MASK_W-1:0] mem_rdata
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_GETSUP = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  sup_q;
	logic [CNT_W-1:0]  sub_q;
	logic [MASK_W-1:0] big_q;
	logic              pend_vld_s1;
	logic [CNT_W-1:0]  pend_sub_s1;
	logic              done_q;
	spp_result_t       result_q;

	logic             accept;
	logic             sup_lt;
	logic             sub_lt;
	logic             room;
	logic [CNT_W-1:0] sup_nxt;
	logic             sup_nxt_lt;
	logic             hit;

	assign accept     = start && (state_q == S_IDLE);
	assign sup_lt     = sup_q < count_q;
	assign sub_lt     = sub_q < count_q;
	assign room       = count_q < SET_LIMIT;
	assign sup_nxt    = sup_q + CNT_W'(1);
	assign sup_nxt_lt = sup_nxt < count_q;

	// read data is the candidate subset issued last cycle
	assign hit = pend_vld_s1 && (pend_sub_s1 != sup_q) &&
		((mem_rdata & ~big_q) == {MASK_W{1'b0}});

	always_comb begin
		mem_req       = '0;
		mem_req.waddr = count_q[IDX_W-1:0];
		mem_req.wdata = cmd.set_members & VERTEX_MASK;
		mem_req.we    = accept && (cmd.func == FUNC_LOAD) && room;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.func[1] && sup_lt) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = sup_q[IDX_W-1:0];
				end
			end
			S_GETSUP: begin
				if (sub_lt) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = sub_q[IDX_W-1:0];
				end
			end
			S_SCAN: begin
				if (!hit) begin
					if (sub_lt) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = sub_q[IDX_W-1:0];
					end else if (sup_nxt_lt) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = sup_nxt[IDX_W-1:0];
					end
				end
			end
			default: begin
				mem_req.re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sup_q       <= '0;
			sub_q       <= '0;
			pend_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.func)
							FUNC_CLEAR: begin
								count_q  <= '0;
								sup_q    <= '0;
								sub_q    <= '0;
								done_q   <= 1'b1;
							end
							FUNC_LOAD: begin
								sup_q  <= '0;
								sub_q  <= '0;
								done_q <= 1'b1;
								if (room) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							default: begin
								if (sup_lt) begin
									state_q <= S_GETSUP;
								end else begin
									sup_q  <= count_q;
									sub_q  <= '0;
									done_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_GETSUP: begin
					pend_vld_s1 <= sub_lt;
					if (sub_lt) begin
						sub_q <= sub_q + CNT_W'(1);
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						sub_q       <= pend_sub_s1 + CNT_W'(1);
						pend_vld_s1 <= 1'b0;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else if (sub_lt) begin
						pend_vld_s1 <= 1'b1;
						sub_q       <= sub_q + CNT_W'(1);
					end else begin
						pend_vld_s1 <= 1'b0;
						if (sup_nxt_lt) begin
							sup_q   <= sup_nxt;
							sub_q   <= '0;
							state_q <= S_GETSUP;
						end else begin
							sup_q   <= count_q;
							sub_q   <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					result_q.superset_index <= '0;
					result_q.subset_index   <= '0;
					unique case (cmd.func)
						FUNC_CLEAR: result_q.status <= STAT_CLEARED;
						FUNC_LOAD:  result_q.status <= room ? STAT_STORED : STAT_FULL;
						default:    result_q.status <= STAT_DONE;
					endcase
				end
			end
			S_GETSUP: begin
				big_q       <= mem_rdata;
				pend_sub_s1 <= sub_q;
			end
			S_SCAN: begin
				if (hit) begin
					result_q.status         <= STAT_PAIR;
					result_q.superset_index <= out_idx(sup_q);
					result_q.subset_index   <= out_idx(pend_sub_s1);
				end else begin
					result_q.status         <= STAT_DONE;
					result_q.superset_index <= '0;
					result_q.subset_index   <= '0;
					pend_sub_s1             <= sub_q;
				end
			end
			default: begin
				big_q <= big_q;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

/* rtl/subset_pairs_pairwise_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// subset_pairs_pairwise_unit
// Stores up to MAX_SETS vertex masks and returns, one per fetch, the next
// (superset, subset) pair in ascending superset then subset order.
//
//   port     dir  kind        notes
//   start    in   strobe      word taken when start && !busy
//   cmd      in   spp_cmd_t   func, set_members
//   busy     out  level       high while a fetch scans
//   done     out  strobe      one cycle per word on result
//   result   out  spp_result_t status, superset_index, subset_index
//
// Clear and load do not raise busy; the result word shows the cycle after the word is taken.
// A fetch holds busy while it scans, one candidate per cycle on the single
// memory read port apart from the read of each new superset; the result
// word shows as busy falls. A fetch with no sets left does not raise busy.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset empties the store and rewinds the scan; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module subset_pairs_pairwise_unit
	import spp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire spp_cmd_t cmd,
	output logic          busy,
	output logic          done,
	output spp_result_t   result
);

	spp_mem_req_t      mem_req;
	logic [MASK_W-1:0] mem_rdata;

	spp_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	spp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule
`default_nettype wire

/* test/subset_pairs_pairwise_unit_tb.sv */
// ----------------------------------------------------------------------------
// subset_pairs_pairwise_unit_tb
// Self-checking bench for the subset pair finder. Words go in through the
// start/busy handshake with random gaps. A scoreboard class tracks its own copy
// of the set store and scan cursors, predicts the result word of every accepted
// word and checks each done strobe field by field. Stimulus covers a directed
// opening, a full-store fill and many random sequences of related sets
// followed by fetches.
// ----------------------------------------------------------------------------
module subset_pairs_pairwise_unit_tb;
	import spp_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int         LIMIT      = 2_000_000;
	localparam int         RANDOM_WORDS = 1700;

	class subset_pair_tracker;
		logic [MASK_W-1:0] masks [MAX_SETS];
		int                set_total;
		int                scan_sup;
		int                scan_sub;
		spp_result_t       pending_results [$];
		int                errors;
		int                pairs, finished, stored, dropped, cleared;

		function new();
			set_total = 0;
			scan_sup  = 0;
			scan_sub  = 0;
			errors    = 0;
			pairs     = 0;
			finished  = 0;
			stored    = 0;
			dropped   = 0;
			cleared   = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// predict the answer to one accepted word
		function void note_command(spp_cmd_t c);
			spp_result_t r;
			bit          found;
			r = '0;
			found = 1'b0;
			if (c.func == FUNC_CLEAR) begin
				set_total = 0;
				scan_sup  = 0;
				scan_sub  = 0;
				r.status  = STAT_CLEARED;
				cleared++;
			end else if (c.func == FUNC_LOAD) begin
				scan_sup = 0;
				scan_sub = 0;
				if (set_total < MAX_SETS) begin
					masks[set_total] = c.set_members & VERTEX_MASK;
					set_total++;
					r.status = STAT_STORED;
					stored++;
				end else begin
					r.status = STAT_FULL;
					dropped++;
				end
			end else begin
				// high bit of func selects fetch
				while (!found && scan_sup < set_total) begin
					while (!found && scan_sub < set_total) begin
						if (scan_sub != scan_sup &&
						    (masks[scan_sub] & ~masks[scan_sup]) == '0)
							found = 1'b1;
						else
							scan_sub++;
					end
					if (!found) begin
						scan_sup++;
						scan_sub = 0;
					end
				end
				if (found) begin
					r.status         = STAT_PAIR;
					r.superset_index = OUT_IDX_W'(scan_sup);
					r.subset_index   = OUT_IDX_W'(scan_sub);
					scan_sub++;
					pairs++;
				end else begin
					scan_sup = set_total;
					scan_sub = 0;
					r.status = STAT_DONE;
					finished++;
				end
			end
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_result(spp_result_t got);
			spp_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing expected: status %0d sup %0d sub %0d",
					$time, got.status, got.superset_index, got.subset_index);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.superset_index !== want.superset_index) begin
				$display("%0t: superset_index expected %0d actual %0d",
					$time, want.superset_index, got.superset_index);
				errors++;
			end
			if (got.subset_index !== want.subset_index) begin
				$display("%0t: subset_index expected %0d actual %0d",
					$time, want.subset_index, got.subset_index);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	spp_cmd_t    cmd;
	logic        busy;
	logic        done;
	spp_result_t result;

	subset_pair_tracker board;
	int                 words_sent = 0;
	int                 cycle_count = 0;
	bit                 quiet = 1'b0;

	subset_pairs_pairwise_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// observe both sides with pre-edge values
	always @(posedge clk) begin
		if (arst_n === 1'b1 && board != null) begin
			if (start === 1'b1 && busy === 1'b0)
				board.note_command(cmd);
			if (done !== 1'b0)
				board.check_result(result);
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_mask();
		case ($urandom_range(0, 2))
			0: return rand64();
			1: return rand64() & rand64();
			default: return rand64() | rand64();
		endcase
	endfunction

	// sets built around a base so that containment is common
	function automatic logic [63:0] related_mask(logic [63:0] base);
		case ($urandom_range(0, 6))
			0: return base;
			1: return base & rand64();
			2: return base | rand64();
			3: return '0;
			4: return '1;
			5: return rand_mask();
			default: return base & rand64() & rand64();
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic [1:0] f, input logic [63:0] members);
		spp_cmd_t c;
		int       gap;
		c.func        = f;
		c.set_members = members;
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		words_sent++;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			start <= 1'b0;
			cmd   <= {FUNC_SPARE, rand64()};
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int          seq_no;
		int          n;
		int          fetches;
		int          first_random;
		logic [63:0] base;

		board  = new();
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty store, extremes, equal sets, spare code, restart
		send_word(FUNC_FETCH, '0);
		send_word(FUNC_SPARE, '1);
		send_word(FUNC_CLEAR, '1);
		send_word(FUNC_LOAD, '1);
		send_word(FUNC_LOAD, '0);
		send_word(FUNC_LOAD, 64'h5555_5555_5555_5555);
		send_word(FUNC_LOAD, 64'h5555_5555_5555_5555);
		send_word(FUNC_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(FUNC_LOAD, 64'h8000_0000_0000_0001);
		for (int i = 0; i < 8; i++)
			send_word((i % 3 == 2) ? FUNC_SPARE : FUNC_FETCH, rand64());
		send_word(FUNC_LOAD, 64'h0000_0000_0000_0001);
		send_word(FUNC_FETCH, '0);
		send_word(FUNC_FETCH, '0);
		send_word(FUNC_CLEAR, '0);
		send_word(FUNC_FETCH, '0);
		drain_results();

		// fill the store; the empty last set puts index 255 into the pairs
		quiet = 1'b1;
		send_word(FUNC_CLEAR, '0);
		for (int i = 0; i < MAX_SETS; i++) begin
			if (i == MAX_SETS - 2)
				send_word(FUNC_LOAD, '1);
			else if (i == MAX_SETS - 1)
				send_word(FUNC_LOAD, '0);
			else
				send_word(FUNC_LOAD, rand64());
		end
		for (int i = 0; i < 4; i++)
			send_word(FUNC_FETCH, '0);
		send_word(FUNC_LOAD, '1);
		send_word(FUNC_FETCH, '0);
		send_word(FUNC_CLEAR, '0);
		quiet = 1'b0;

		// random sequences: load related sets, then fetch through the pairs
		seq_no = 0;
		first_random = words_sent;
		while (words_sent - first_random < RANDOM_WORDS) begin
			seq_no++;
			quiet = ($urandom_range(0, 4) == 0);
			if (seq_no % 10 == 0)
				drain_results();
			if ($urandom_range(0, 6) != 0)
				send_word(FUNC_CLEAR, rand64());
			n    = $urandom_range(1, 8);
			base = rand_mask();
			for (int i = 0; i < n; i++)
				send_word(FUNC_LOAD, related_mask(base));
			fetches = ($urandom_range(0, 3) != 0) ? n * (n - 1) + 2 : $urandom_range(1, n * n);
			for (int i = 0; i < fetches; i++) begin
				// a load in mid scan rewinds it
				if ($urandom_range(0, 19) == 0)
					send_word(FUNC_LOAD, related_mask(base));
				send_word(($urandom_range(0, 3) == 0) ? FUNC_SPARE : FUNC_FETCH, rand64());
			end
		end

		drain_results();
		repeat (20) @(posedge clk);

		$display("%0d words in %0d random sequences after directed and full-store phases",
			words_sent, seq_no);
		$display("answers: %0d pairs, %0d scan done, %0d stored, %0d dropped, %0d clears",
			board.pairs, board.finished, board.stored, board.dropped, board.cleared);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results never seen", board.errors, board.pending());
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* subset_pairs_pairwise_unit.f */
rtl/spp_pkg.sv
rtl/spp_store.sv
rtl/spp_seq.sv
rtl/subset_pairs_pairwise_unit.sv
test/subset_pairs_pairwise_unit_tb.sv
